// ===== rtl/decaying_wetness_map_unit_macros.svh =====
// Assertion macros used by the wetness map checker.
`ifndef DECAYING_WETNESS_MAP_UNIT_MACROS_SVH
`define DECAYING_WETNESS_MAP_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DWM_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wetness map check failed");

// Consequent must hold in the cycle after the antecedent.
`define DWM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wetness map check failed");

`endif

// ===== rtl/dwm_pkg.sv =====
// Shared types, codes and sizing helpers of the decaying wetness map.
package dwm_pkg;

   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [7:0] WET_FULL = 8'hFF;

   // Register index taken from paddr[2].
   localparam logic CSR_IDX_WIDTH  = 1'b0;
   localparam logic CSR_IDX_HEIGHT = 1'b1;

   typedef enum logic [1:0] {
      OP_TICK = 2'd0,
      OP_FILL = 2'd1,
      OP_READ = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef struct packed {
      op_type op;
      logic   in_map;
   } cmd_ctl_type;

   function automatic int addr_bits(int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

   localparam int DEF_ADDR_W = addr_bits(DEF_MAX_WIDTH * DEF_MAX_HEIGHT);

endpackage

// ===== rtl/dwm_front.sv =====
// Front end: takes request items, resolves the point and linear address.
module dwm_front #(
   parameter int MAX_WIDTH  = dwm_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = dwm_pkg::DEF_MAX_HEIGHT,
   parameter int ADDR_W     = dwm_pkg::DEF_ADDR_W
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_type,
   input  logic signed [15:0]  req_pos_x,
   input  logic signed [15:0]  req_pos_y,
   input  logic signed [15:0]  req_shift_x,
   input  logic signed [15:0]  req_shift_y,
   input  logic [8:0]          map_width,
   input  logic [8:0]          map_height,
   input  logic                clearing,
   input  logic                q_full,
   output logic                push,
   output dwm_pkg::cmd_ctl_type push_ctl,
   output logic [ADDR_W-1:0]   push_addr,
   output logic [ADDR_W:0]     push_span
);
   import dwm_pkg::*;

   localparam logic [8:0] LIM_W = (MAX_WIDTH > 511) ? 9'd511 : 9'(MAX_WIDTH);
   localparam logic [8:0] LIM_H = (MAX_HEIGHT > 511) ? 9'd511 : 9'(MAX_HEIGHT);

   logic               valid_ff, valid_in;
   op_type             op_ff;
   logic signed [15:0] px_ff, py_ff, sx_ff, sy_ff;
   logic               accept;

   logic [8:0]         eff_w, eff_h;
   logic signed [16:0] pt_x, pt_y;
   logic               in_x, in_y;
   logic [17:0]        row_base;
   logic [18:0]        lin;
   logic [17:0]        area;

   assign push   = valid_ff && !q_full;
   assign busy   = clearing || (valid_ff && !push);
   assign accept = start && !busy;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= op_type'(req_type);
         px_ff <= req_pos_x;
         py_ff <= req_pos_y;
         sx_ff <= req_shift_x;
         sy_ff <= req_shift_y;
      end
   end

   always_comb begin
      eff_w = (map_width  > LIM_W) ? LIM_W : map_width;
      eff_h = (map_height > LIM_H) ? LIM_H : map_height;

      // Fill points carry the offset; the sum never wraps at 17 bits.
      if (op_ff == OP_FILL) begin
         pt_x = 17'(px_ff) + 17'(sx_ff);
         pt_y = 17'(py_ff) + 17'(sy_ff);
      end else begin
         pt_x = 17'(px_ff);
         pt_y = 17'(py_ff);
      end

      in_x = !pt_x[16] && (pt_x[15:0] < {7'b0, eff_w});
      in_y = !pt_y[16] && (pt_y[15:0] < {7'b0, eff_h});

      row_base = {9'b0, pt_y[8:0]} * {9'b0, eff_w};
      lin      = {10'b0, pt_x[8:0]} + {1'b0, row_base};
      area     = {9'b0, eff_w} * {9'b0, eff_h};

      push_ctl.op     = op_ff;
      push_ctl.in_map = in_x && in_y && ((op_ff == OP_FILL) || (op_ff == OP_READ));
      push_addr       = ADDR_W'(lin);
      push_span       = (ADDR_W + 1)'(area);
   end

endmodule

// ===== rtl/dwm_queue.sv =====
// Short command queue between the front end and the map engine.
module dwm_queue #(
   parameter int ADDR_W = dwm_pkg::DEF_ADDR_W
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  dwm_pkg::cmd_ctl_type push_ctl,
   input  logic [ADDR_W-1:0]    push_addr,
   input  logic [ADDR_W:0]      push_span,
   output logic                 full,
   input  logic                 pop,
   output logic                 q_valid,
   output dwm_pkg::cmd_ctl_type head_ctl,
   output logic [ADDR_W-1:0]    head_addr,
   output logic [ADDR_W:0]      head_span
);
   import dwm_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_ctl_type       ctl_ff  [QUEUE_DEPTH];
   logic [ADDR_W-1:0] addr_ff [QUEUE_DEPTH];
   logic [ADDR_W:0]   span_ff [QUEUE_DEPTH];

   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign q_valid   = (count_ff != '0);
   assign head_ctl  = ctl_ff[rd_ptr_ff];
   assign head_addr = addr_ff[rd_ptr_ff];
   assign head_span = span_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ctl_ff[wr_ptr_ff]  <= push_ctl;
         addr_ff[wr_ptr_ff] <= push_addr;
         span_ff[wr_ptr_ff] <= push_span;
      end
   end

endmodule

// ===== rtl/dwm_back.sv =====
// Map engine: owns the wetness memory, runs fills, reads, decay sweeps, clear.
module dwm_back #(
   parameter int MAX_WIDTH  = dwm_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = dwm_pkg::DEF_MAX_HEIGHT,
   parameter int ADDR_W     = dwm_pkg::DEF_ADDR_W
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  dwm_pkg::cmd_ctl_type head_ctl,
   input  logic [ADDR_W-1:0]    head_addr,
   input  logic [ADDR_W:0]      head_span,
   output logic                 pop,
   output logic                 clearing,
   output logic                 rsp_strobe,
   output logic [7:0]           rsp_water,
   output logic                 rsp_inside_res
);
   import dwm_pkg::*;

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_READ  = 5'b00100,
      ST_SWEEP = 5'b01000,
      ST_DRAIN = 5'b10000
   } back_state_type;

   logic [7:0]        mem [DEPTH];
   logic [7:0]        rd_data_ff;

   back_state_type    state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [ADDR_W:0]   sweep_ff, sweep_in;
   logic [ADDR_W:0]   span_ff, span_in;
   logic              wb_valid_ff, wb_valid_in;
   logic [ADDR_W-1:0] wb_addr_ff, wb_addr_in;
   logic              rd_inside_ff, rd_inside_in;
   logic              strobe_ff, strobe_in;
   logic [7:0]        water_ff, water_in;
   logic              inside_ff, inside_in;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [7:0]        wr_data, dec_data;

   assign clearing       = (state_ff == ST_CLEAR);
   assign rsp_strobe     = strobe_ff;
   assign rsp_water      = water_ff;
   assign rsp_inside_res = inside_ff;
   assign dec_data       = (rd_data_ff != 8'd0) ? rd_data_ff - 8'd1 : 8'd0;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      sweep_in     = sweep_ff;
      span_in      = span_ff;
      wb_valid_in  = 1'b0;
      wb_addr_in   = wb_addr_ff;
      rd_inside_in = rd_inside_ff;
      strobe_in    = 1'b0;
      water_in     = 8'd0;
      inside_in    = 1'b0;
      pop          = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = head_addr;
      wr_data      = WET_FULL;
      rd_addr      = head_addr;
      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = 8'd0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               pop = 1'b1;
               case (head_ctl.op)
                  OP_FILL: begin
                     wr_en     = head_ctl.in_map;
                     strobe_in = 1'b1;
                     inside_in = head_ctl.in_map;
                  end
                  OP_READ: begin
                     rd_inside_in = head_ctl.in_map;
                     state_in     = ST_READ;
                  end
                  OP_TICK: begin
                     if (head_span == '0) begin
                        strobe_in = 1'b1;
                     end else begin
                        span_in  = head_span;
                        sweep_in = '0;
                        state_in = ST_SWEEP;
                     end
                  end
                  default: begin
                     strobe_in = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            strobe_in = 1'b1;
            inside_in = rd_inside_ff;
            water_in  = rd_inside_ff ? rd_data_ff : 8'd0;
            state_in  = ST_IDLE;
         end
         ST_SWEEP: begin
            // Read the next entry while the previous one is written back.
            rd_addr     = sweep_ff[ADDR_W-1:0];
            wr_en       = wb_valid_ff;
            wr_addr     = wb_addr_ff;
            wr_data     = dec_data;
            wb_valid_in = 1'b1;
            wb_addr_in  = sweep_ff[ADDR_W-1:0];
            sweep_in    = sweep_ff + 1'b1;
            if (sweep_in == span_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            wr_en     = 1'b1;
            wr_addr   = wb_addr_ff;
            wr_data   = dec_data;
            strobe_in = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_ff      <= '0;
         wb_valid_ff <= 1'b0;
         strobe_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_ff      <= clr_in;
         wb_valid_ff <= wb_valid_in;
         strobe_ff   <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      sweep_ff     <= sweep_in;
      span_ff      <= span_in;
      wb_addr_ff   <= wb_addr_in;
      rd_inside_ff <= rd_inside_in;
      water_ff     <= water_in;
      inside_ff    <= inside_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

// ===== rtl/decaying_wetness_map_unit.sv =====
// Top level of the decaying wetness map: register port, front end, queue, map engine.
//
// Usage:
//   Request channel: drive req_type and the point fields and raise start; an item is taken
//   at a rising edge with start high and busy low. Codes: tick (decay the active area by
//   one), fill (set the shifted point to full wetness), read (return the point's value).
//   Result channel: every item yields exactly one result, shown for one cycle with
//   rsp_strobe high. The receiver cannot stall it, so results are never held back.
//   Register port: map_width at byte 0, map_height at byte 4, written by an APB access
//   cycle; pready is tied high. Write only while the block is idle.
// Timing:
//   A fill result passes the front-end register, the queue and the result register; a read
//   also waits for the registered read data of the single memory read port. Fills sustain
//   one item per cycle unless a read, a tick or the clearing pass holds the engine. A tick
//   over a nonempty area holds it through a sweep and a drain state: one entry per cycle is
//   read, decremented and written back through the same memory.
//   The front end keeps taking items while the 2-entry queue has room.
// Reset:
//   The map engine clears all MAX_WIDTH*MAX_HEIGHT entries of the memory with busy high;
//   register writes are taken during that pass.
module decaying_wetness_map_unit #(
   parameter int MAX_WIDTH  = dwm_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = dwm_pkg::DEF_MAX_HEIGHT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_type,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic signed [15:0] req_shift_x,
   input  logic signed [15:0] req_shift_y,
   output logic               rsp_strobe,
   output logic [7:0]         rsp_water,
   output logic               rsp_inside_res,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import dwm_pkg::*;

   localparam int ADDR_W = addr_bits(MAX_WIDTH * MAX_HEIGHT);

   logic [8:0]        map_width_ff, map_width_in;
   logic [8:0]        map_height_ff, map_height_in;
   logic              csr_write;

   logic              clearing;
   logic              q_full, q_valid, push, pop;
   cmd_ctl_type       push_ctl, head_ctl;
   logic [ADDR_W-1:0] push_addr, head_addr;
   logic [ADDR_W:0]   push_span, head_span;

   // Register port: never inserts wait states, write on the access cycle.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == CSR_IDX_HEIGHT) ? {23'b0, map_height_ff}
                                                   : {23'b0, map_width_ff};

   always_comb begin
      map_width_in  = map_width_ff;
      map_height_in = map_height_ff;
      if (csr_write) begin
         if (paddr[2] == CSR_IDX_WIDTH) begin
            map_width_in = pwdata[8:0];
         end else begin
            map_height_in = pwdata[8:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff  <= 9'd256;
         map_height_ff <= 9'd256;
      end else begin
         map_width_ff  <= map_width_in;
         map_height_ff <= map_height_in;
      end
   end

   // Take and resolve items; stall on a full queue or during the clearing pass.
   dwm_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .ADDR_W     (ADDR_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_type    (req_type),
      .req_pos_x   (req_pos_x),
      .req_pos_y   (req_pos_y),
      .req_shift_x (req_shift_x),
      .req_shift_y (req_shift_y),
      .map_width   (map_width_ff),
      .map_height  (map_height_ff),
      .clearing    (clearing),
      .q_full      (q_full),
      .push        (push),
      .push_ctl    (push_ctl),
      .push_addr   (push_addr),
      .push_span   (push_span)
   );

   // Hold resolved commands until the engine is free.
   dwm_queue #(
      .ADDR_W (ADDR_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_ctl  (push_ctl),
      .push_addr (push_addr),
      .push_span (push_span),
      .full      (q_full),
      .pop       (pop),
      .q_valid   (q_valid),
      .head_ctl  (head_ctl),
      .head_addr (head_addr),
      .head_span (head_span)
   );

   // Carry out commands against the wetness memory and drive results.
   dwm_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .ADDR_W     (ADDR_W)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .head_ctl       (head_ctl),
      .head_addr      (head_addr),
      .head_span      (head_span),
      .pop            (pop),
      .clearing       (clearing),
      .rsp_strobe     (rsp_strobe),
      .rsp_water      (rsp_water),
      .rsp_inside_res (rsp_inside_res)
   );

endmodule

// ===== rtl/dwm_checker.sv =====
// Port-level checks of the wetness map and their binding to the top level.
`include "decaying_wetness_map_unit_macros.svh"

module dwm_checker (
   input logic       clock,
   input logic       reset,
   input logic       busy,
   input logic       rsp_strobe,
   input logic [7:0] rsp_water,
   input logic       rsp_inside_res,
   input logic       pready
);

   // The clearing pass starts right after reset, so no item may be taken then.
   `DWM_ASSERT_NOW(a_busy_after_reset, clock, 1'b0, $past(reset), busy)

   // No result is shown in the cycle after a reset edge.
   `DWM_ASSERT_NEXT(a_no_result_after_reset, clock, 1'b0, reset, !rsp_strobe)

   // Wet values only come from reads of points inside the map.
   `DWM_ASSERT_NOW(a_water_needs_inside, clock, reset, rsp_strobe && |rsp_water, rsp_inside_res)

   // Register port never inserts wait states.
   `DWM_ASSERT_NOW(a_pready_high, clock, 1'b0, 1'b1, pready)

endmodule

bind decaying_wetness_map_unit dwm_checker u_checker (.*);

// ===== tb/wetness_mirror_pkg.sv =====
// Request and readout types plus the scoreboard that mirrors the wetness map.
package wetness_mirror_pkg;

   import dwm_pkg::*;

   localparam int MAP_DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;

   typedef struct {
      op_type             op;
      logic signed [15:0] px;
      logic signed [15:0] py;
      logic signed [15:0] sx;
      logic signed [15:0] sy;
   } map_request;

   typedef struct {
      op_type     op;
      logic [7:0] water;
      logic       in_map;
   } map_readout;

   class wetness_mirror;
      logic [7:0] wetness [MAP_DEPTH];
      logic [8:0] width_reg;
      logic [8:0] height_reg;
      map_readout pending_readouts [$];
      int         failures;

      function new();
         foreach (wetness[i]) wetness[i] = 8'd0;
         width_reg  = 9'd256;
         height_reg = 9'd256;
         failures   = 0;
      endfunction

      function int active_width();
         return (width_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(width_reg);
      endfunction

      function int active_height();
         return (height_reg > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(height_reg);
      endfunction

      function int pending();
         return pending_readouts.size();
      endfunction

      function void set_size(logic idx, logic [8:0] value);
         if (idx == CSR_IDX_WIDTH) width_reg = value;
         else height_reg = value;
      endfunction

      // Linear address is x + y * active width, so a width change reshapes the map.
      function bit locate(int x, int y, output int addr);
         int w;
         int h;
         w = active_width();
         h = active_height();
         addr = 0;
         if (x < 0 || y < 0 || x >= w || y >= h) return 1'b0;
         addr = x + y * w;
         return addr < MAP_DEPTH;
      endfunction

      function void apply_request(map_request r);
         map_readout res;
         int         addr;
         int         area;
         res.op     = r.op;
         res.water  = 8'd0;
         res.in_map = 1'b0;
         case (r.op)
            OP_TICK: begin
               area = active_width() * active_height();
               if (area > MAP_DEPTH) area = MAP_DEPTH;
               for (int i = 0; i < area; i++)
                  if (wetness[i] != 8'd0) wetness[i] = wetness[i] - 8'd1;
            end
            OP_FILL: begin
               if (locate(int'(r.px) + int'(r.sx), int'(r.py) + int'(r.sy), addr)) begin
                  wetness[addr] = WET_FULL;
                  res.in_map    = 1'b1;
               end
            end
            OP_READ: begin
               if (locate(int'(r.px), int'(r.py), addr)) begin
                  res.water  = wetness[addr];
                  res.in_map = 1'b1;
               end
            end
            default: ;
         endcase
         pending_readouts.push_back(res);
      endfunction

      function void check_readout(logic [7:0] water, logic in_map);
         map_readout exp;
         if (pending_readouts.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected result: water=%0d inside=%0b", water, in_map);
            return;
         end
         exp = pending_readouts.pop_front();
         if (water !== exp.water || in_map !== exp.in_map) begin
            failures++;
            if (failures <= 10)
               $display("mismatch on %s: expected water=%0d inside=%0b, got water=%0d inside=%0b",
                        exp.op.name(), exp.water, exp.in_map, water, in_map);
         end
      endfunction

      function void check_register(logic idx, logic [31:0] data);
         logic [8:0] exp;
         exp = (idx == CSR_IDX_WIDTH) ? width_reg : height_reg;
         if (data !== {23'd0, exp}) begin
            failures++;
            if (failures <= 10)
               $display("register %0d readback: expected %0d, got %0d", idx, exp, data);
         end
      endfunction
   endclass

endpackage

// ===== tb/decaying_wetness_map_unit_test.sv =====
// Top of the wetness map testbench: clock, reset, drivers, monitor and the run itself.
module decaying_wetness_map_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import dwm_pkg::*;
   import wetness_mirror_pkg::*;

   localparam int HALF_PERIOD = 5;

   typedef struct {
      int x;
      int y;
   } point;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [1:0]         req_type;
   logic signed [15:0] req_pos_x;
   logic signed [15:0] req_pos_y;
   logic signed [15:0] req_shift_x;
   logic signed [15:0] req_shift_y;
   logic               rsp_strobe;
   logic [7:0]         rsp_water;
   logic               rsp_inside_res;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [2:0]         paddr;
   logic [31:0]        pwdata;
   logic [31:0]        prdata;
   logic               pready;

   wetness_mirror mirror;
   point          wet_spots [$];

   int size_w [6] = '{8, 16, 1, 32, 5, 3};
   int size_h [6] = '{8, 4, 32, 32, 13, 1};
   int idle_pct [6] = '{0, 45, 19, 0, 45, 19};

   decaying_wetness_map_unit dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_type      (req_type),
      .req_pos_x     (req_pos_x),
      .req_pos_y     (req_pos_y),
      .req_shift_x   (req_shift_x),
      .req_shift_y   (req_shift_y),
      .rsp_strobe    (rsp_strobe),
      .rsp_water     (rsp_water),
      .rsp_inside_res(rsp_inside_res),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   always #HALF_PERIOD clock = ~clock;

   // Sample both channels on the rising edge. Results always belong to older
   // items, so check the result before noting a newly taken item.
   always @(posedge clock) begin
      map_request r;
      if (!reset) begin
         if (rsp_strobe) mirror.check_readout(rsp_water, rsp_inside_res);
         if (start && !busy) begin
            r.op = op_type'(req_type);
            r.px = req_pos_x;
            r.py = req_pos_y;
            r.sx = req_shift_x;
            r.sy = req_shift_y;
            mirror.apply_request(r);
         end
      end
   end

   // Hold the item on the ports from the falling edge until the block takes it.
   task automatic send_item(input map_request r);
      @(negedge clock);
      start       <= 1'b1;
      req_type    <= r.op;
      req_pos_x   <= r.px;
      req_pos_y   <= r.py;
      req_shift_x <= r.sx;
      req_shift_y <= r.sy;
      do @(posedge clock); while (busy);
   endtask

   task automatic issue(input op_type op, input int px, input int py, input int sx,
                        input int sy);
      map_request r;
      r.op = op;
      r.px = 16'(px);
      r.py = 16'(py);
      r.sx = 16'(sx);
      r.sy = 16'(sy);
      send_item(r);
   endtask

   // Drop start and hold it low for the number of cycles given.
   task automatic idle_sender(input int cycles);
      @(negedge clock);
      start <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Drop start and hold until every expected result is in, then let the
   // engine finish whatever it still has in hand.
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (mirror.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Write a size register, then read it straight back with psel held high.
   task automatic write_size(input logic idx, input logic [8:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {23'd0, value};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      mirror.set_size(idx, value);
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      mirror.check_register(idx, prdata);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_map(input logic [8:0] w, input logic [8:0] h);
      drain();
      write_size(CSR_IDX_WIDTH, w);
      write_size(CSR_IDX_HEIGHT, h);
   endtask

   // Mostly well-formed work: fills that land inside the map, reads of spots
   // filled lately, a few ticks to age them; the rest is full-range noise.
   function automatic map_request random_item();
      map_request r;
      point       p;
      int         w;
      int         h;
      int         pick;
      int         sx;
      int         sy;
      w    = mirror.active_width();
      h    = mirror.active_height();
      pick = $urandom_range(99);
      r.px = 16'($urandom);
      r.py = 16'($urandom);
      r.sx = 16'($urandom);
      r.sy = 16'($urandom);
      if (pick < 8) begin
         r.op = OP_TICK;
      end else if (pick < 11) begin
         r.op = OP_NONE;
      end else if (pick < 56) begin
         r.op = OP_FILL;
         if ($urandom_range(9) < 8 && w > 0 && h > 0) begin
            p.x = $urandom_range(w - 1);
            p.y = $urandom_range(h - 1);
            if ($urandom_range(1) == 1) begin
               sx = int'(r.sx);
               sy = int'(r.sy);
            end else begin
               sx = int'($urandom_range(80)) - 40;
               sy = int'($urandom_range(80)) - 40;
            end
            // Keep the unshifted point representable in 16 bits.
            if (p.x - sx < -32768 || p.x - sx > 32767) sx = 0;
            if (p.y - sy < -32768 || p.y - sy > 32767) sy = 0;
            r.px = 16'(p.x - sx);
            r.py = 16'(p.y - sy);
            r.sx = 16'(sx);
            r.sy = 16'(sy);
            wet_spots.push_back(p);
            if (wet_spots.size() > 12) void'(wet_spots.pop_front());
         end
      end else begin
         r.op = OP_READ;
         pick = $urandom_range(99);
         if (pick < 70 && wet_spots.size() > 0) begin
            p    = wet_spots[$urandom_range(wet_spots.size() - 1)];
            r.px = 16'(p.x);
            r.py = 16'(p.y);
         end else if (pick < 85 && w > 0 && h > 0) begin
            r.px = 16'($urandom_range(w - 1));
            r.py = 16'($urandom_range(h - 1));
         end
      end
      return r;
   endfunction

   initial begin
      mirror      = new();
      clock       = 1'b0;
      reset       = 1'b1;
      start       = 1'b0;
      req_type    = OP_TICK;
      req_pos_x   = '0;
      req_pos_y   = '0;
      req_shift_x = '0;
      req_shift_y = '0;
      psel        = 1'b0;
      penable     = 1'b0;
      pwrite      = 1'b0;
      paddr       = '0;
      pwdata      = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Full-size map after reset. The first item waits out the clearing pass.
      issue(OP_READ, 0, 0, 0, 0);
      issue(OP_READ, 255, 255, 0, 0);
      issue(OP_FILL, 255, 255, 0, 0);
      issue(OP_READ, 255, 255, 0, 0);
      issue(OP_FILL, 10, 20, -10, -20);
      issue(OP_READ, 0, 0, 0, 0);
      // Shifted sums near and past the 16-bit limits; those past 16 bits must not wrap back into the map.
      issue(OP_FILL, -32768, -32768, -32768, -32768);
      issue(OP_FILL, 32767, 32767, 32767, 32767);
      issue(OP_FILL, 32767, -32768, -32512, 32767);
      issue(OP_FILL, -32768, 0, 32767, 0);
      issue(OP_FILL, 32767, 200, -32767, 0);
      issue(OP_READ, 0, 0, 0, 0);
      issue(OP_TICK, 0, 0, 0, 0);
      issue(OP_READ, 0, 0, 0, 0);
      issue(OP_READ, 255, 255, 0, 0);
      issue(OP_READ, 0, 200, 0, 0);
      issue(OP_READ, 256, 0, 0, 0);
      issue(OP_READ, 0, 256, 0, 0);
      issue(OP_READ, -1, 0, 0, 0);
      issue(OP_READ, 32767, -32768, 0, 0);
      issue(OP_NONE, -1, -1, -1, -1);
      issue(OP_READ, 0, 0, 0, 0);

      // Zero-sized maps: nothing is inside, a tick touches nothing.
      set_map(9'd0, 9'd5);
      issue(OP_FILL, 0, 0, 0, 0);
      issue(OP_READ, 0, 0, 0, 0);
      issue(OP_TICK, 0, 0, 0, 0);
      set_map(9'd5, 9'd0);
      issue(OP_FILL, 0, 0, 0, 0);
      issue(OP_READ, 0, 0, 0, 0);
      issue(OP_TICK, 0, 0, 0, 0);

      // Oversized width saturates at the maximum.
      set_map(9'd511, 9'd3);
      issue(OP_READ, 255, 2, 0, 0);
      issue(OP_FILL, 300, 0, -45, 1);
      issue(OP_READ, 255, 1, 0, 0);
      issue(OP_TICK, 0, 0, 0, 0);
      issue(OP_READ, 255, 1, 0, 0);

      // Narrow map with saturated height reinterprets the stored entries.
      set_map(9'd2, 9'd511);
      issue(OP_READ, 1, 255, 0, 0);
      issue(OP_FILL, 1, 255, 0, 0);
      issue(OP_TICK, 0, 0, 0, 0);
      issue(OP_READ, 1, 255, 0, 0);
      issue(OP_READ, 2, 0, 0, 0);

      set_map(9'd1, 9'd1);
      issue(OP_FILL, 0, 0, 0, 0);
      issue(OP_READ, 0, 0, 0, 0);
      issue(OP_READ, 0, 1, 0, 0);
      issue(OP_TICK, 0, 0, 0, 0);
      issue(OP_READ, 0, 0, 0, 0);

      set_map(9'd511, 9'd511);
      issue(OP_READ, 0, 0, 0, 0);
      issue(OP_TICK, 0, 0, 0, 0);
      issue(OP_READ, 0, 0, 0, 0);
      issue(OP_READ, 255, 255, 0, 0);

      // Random phases on small maps keep the sweeps short. The receiver
      // cannot stall, so only the sender idles.
      for (int phase = 0; phase < 6; phase++) begin
         set_map(9'(size_w[phase]), 9'(size_h[phase]));
         for (int n = 0; n < 125; n++) begin
            if (phase == 1 && n == 60) drain();
            else if (int'($urandom_range(99)) < idle_pct[phase])
               idle_sender($urandom_range(1, 5));
            send_item(random_item());
         end
      end

      drain();
      if (mirror.failures == 0 && mirror.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Bound the run well beyond the slowest correct pass.
   initial begin
      #20_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/dwm_pkg.sv
rtl/dwm_front.sv
rtl/dwm_queue.sv
rtl/dwm_back.sv
rtl/decaying_wetness_map_unit.sv
rtl/dwm_checker.sv
tb/wetness_mirror_pkg.sv
tb/decaying_wetness_map_unit_test.sv
